// File: hw/rtl/oarb_pkg.sv
// shared types and constants of the overwriting audio ring buffer
package oarb_pkg;

  localparam int SAMPLE_W = 16;
  localparam int CMD_W    = 3;
  localparam int SEL_W    = 3;
  localparam int OFF_W    = 9;
  localparam int FRM_W    = 10;
  localparam int CFG_W    = 4;
  localparam int APB_AW   = 3;
  localparam int APB_DW   = 32;

  localparam logic REG_CH_COUNT = 1'b0;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE = 3'd0,
    CMD_READ  = 3'd1,
    CMD_MONO  = 3'd2,
    CMD_PEEK  = 3'd3,
    CMD_CLEAR = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_BAD_CH    = 2'd2,
    ST_OVERWRITE = 2'd3
  } status_e;

  typedef struct packed {
    logic [CMD_W-1:0]           cmd;
    logic signed [SAMPLE_W-1:0] sample_in;
    logic [SEL_W-1:0]           channel_sel;
    logic [OFF_W-1:0]           frame_offset;
  } item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_out;
    logic [1:0]                 status;
    logic [FRM_W-1:0]           frames_available;
    logic [FRM_W-1:0]           frames_writable;
  } res_t;

  typedef struct packed {
    logic    item_load;
    logic    status_load;
    status_e status;
    logic    ram_write;
    logic    read_one;
    logic    mono_start;
    logic    mono_step;
    logic    div_start;
    logic    peek_read;
    logic    sample_from_ram;
    logic    sample_from_div;
    logic    ptr_clear;
    logic    out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    cmd_e cmd;
    logic empty;
    logic no_frame;
    logic full;
    logic sel_bad;
    logic off_bad;
    logic mono_done;
    logic div_done;
  } dp_stat_t;

endpackage

// File: hw/rtl/oarb_intf.sv
// command and result channel interfaces
interface oarb_cmd_if;
  logic               valid;
  logic               ready;
  oarb_pkg::item_t    data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface oarb_res_if;
  logic               valid;
  logic               ready;
  oarb_pkg::res_t     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: hw/rtl/oarb_ram.sv
// generic single-write, single-read ram with registered read data
module oarb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/oarb_div.sv
// bit-serial signed divider, truncating toward zero
module oarb_div #(
  parameter int NUM_W = 20,
  parameter int DEN_W = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quo_o
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [NUM_W-1:0] quo_q;
  logic [DEN_W-1:0] rem_q;
  logic [DEN_W-1:0] den_q;
  logic             neg_q;

  logic [NUM_W-1:0] mag;
  logic [DEN_W:0]   shifted;
  logic [DEN_W:0]   trial;
  logic             fits;
  logic [DEN_W-1:0] rem_d;

  assign mag     = num_i[NUM_W-1] ? (~num_i + 1'b1) : num_i;
  assign shifted = {rem_q, quo_q[NUM_W-1]};
  assign trial   = shifted - {1'b0, den_q};
  assign fits    = (shifted >= {1'b0, den_q});
  assign rem_d   = fits ? trial[DEN_W-1:0] : shifted[DEN_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(NUM_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= mag;
      rem_q <= '0;
      den_q <= den_i;
      neg_q <= num_i[NUM_W-1];
    end else if (busy_q) begin
      quo_q <= {quo_q[NUM_W-2:0], fits};
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign quo_o  = neg_q ? (~quo_q + 1'b1) : quo_q;

endmodule

// File: hw/rtl/oarb_ctrl.sv
// command sequencer of the ring buffer
module oarb_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cmd_valid_i,
  output logic                  cmd_ready_o,
  output logic                  res_valid_o,
  input  logic                  res_ready_i,
  input  oarb_pkg::dp_stat_t    stat_i,
  output oarb_pkg::ctrl_cmd_t   cmd_o
);

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_DISPATCH = 6'b000010,
    S_RDWAIT   = 6'b000100,
    S_MONO     = 6'b001000,
    S_DIV      = 6'b010000,
    S_RESP     = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    cmd_o       = '0;
    cmd_o.status = oarb_pkg::ST_OK;
    state_d     = state_q;
    cmd_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        cmd_ready_o = 1'b1;
        if (cmd_valid_i) begin
          cmd_o.item_load = 1'b1;
          state_d         = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        cmd_o.status_load = 1'b1;
        state_d           = S_RESP;
        case (stat_i.cmd)
          oarb_pkg::CMD_WRITE: begin
            cmd_o.ram_write = 1'b1;
            if (stat_i.full) begin
              cmd_o.status = oarb_pkg::ST_OVERWRITE;
            end
          end
          oarb_pkg::CMD_READ: begin
            if (stat_i.empty) begin
              cmd_o.status = oarb_pkg::ST_EMPTY;
            end else begin
              cmd_o.read_one = 1'b1;
              state_d        = S_RDWAIT;
            end
          end
          oarb_pkg::CMD_MONO: begin
            if (stat_i.no_frame) begin
              cmd_o.status = oarb_pkg::ST_EMPTY;
            end else begin
              cmd_o.mono_start = 1'b1;
              state_d          = S_MONO;
            end
          end
          oarb_pkg::CMD_PEEK: begin
            if (stat_i.sel_bad) begin
              cmd_o.status = oarb_pkg::ST_BAD_CH;
            end else if (stat_i.off_bad) begin
              cmd_o.status = oarb_pkg::ST_EMPTY;
            end else begin
              cmd_o.peek_read = 1'b1;
              state_d         = S_RDWAIT;
            end
          end
          oarb_pkg::CMD_CLEAR: begin
            cmd_o.ptr_clear = 1'b1;
          end
          default: begin
          end
        endcase
      end
      S_RDWAIT: begin
        cmd_o.sample_from_ram = 1'b1;
        state_d               = S_RESP;
      end
      S_MONO: begin
        if (stat_i.mono_done) begin
          cmd_o.div_start = 1'b1;
          state_d         = S_DIV;
        end else begin
          cmd_o.mono_step = 1'b1;
        end
      end
      S_DIV: begin
        if (stat_i.div_done) begin
          cmd_o.sample_from_div = 1'b1;
          state_d               = S_RESP;
        end
      end
      S_RESP: begin
        if (!out_valid_q || res_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (res_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign res_valid_o = out_valid_q;

endmodule

// File: hw/rtl/oarb_dp.sv
// pointers, frame counters, sample store, mono accumulator and result register
module oarb_dp #(
  parameter int FRAMES       = 512,
  parameter int MAX_CHANNELS = 8
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  oarb_pkg::item_t                      item_i,
  input  oarb_pkg::ctrl_cmd_t                  cmd_i,
  output oarb_pkg::dp_stat_t                   stat_o,
  output oarb_pkg::res_t                       res_o,
  input  logic                                 cfg_we_i,
  input  logic [oarb_pkg::CFG_W-1:0]           cfg_wdata_i,
  output logic [$clog2(MAX_CHANNELS+1)-1:0]    ch_o
);

  localparam int STORE   = FRAMES * MAX_CHANNELS;
  localparam int PTR_W   = $clog2(STORE);
  localparam int CAP_W   = $clog2(STORE + 1);
  localparam int CH_W    = $clog2(MAX_CHANNELS + 1);
  localparam int F_W     = $clog2(FRAMES + 1);
  localparam int SUM_W   = oarb_pkg::SAMPLE_W + $clog2(MAX_CHANNELS) + 1;
  localparam int PROD_W  = oarb_pkg::OFF_W + CH_W;
  localparam int CH_RST  = (MAX_CHANNELS < 2) ? MAX_CHANNELS : 2;
  localparam int SW      = oarb_pkg::SAMPLE_W;

  logic [CH_W-1:0]  ch_q, ch_d;
  logic [CAP_W-1:0] cap_q, cap_d;
  logic [PTR_W-1:0] rp_q, rp_d, wp_q, wp_d;
  logic [F_W-1:0]   f_q, f_d;
  logic [CH_W-1:0]  r_q, r_d;
  logic [CH_W-1:0]  left_q, left_d;
  logic             pend_q, pend_d;

  oarb_pkg::item_t  item_q;
  logic [PROD_W-1:0] prod_q;
  logic [SUM_W-1:0] acc_q;
  logic [SW-1:0]    sample_q;
  oarb_pkg::status_e status_q;
  oarb_pkg::res_t   out_q;

  logic [PTR_W:0]   rp_inc, wp_inc;
  logic [PTR_W-1:0] rp_next, wp_next;
  logic [CAP_W:0]   pos_sum, pos;
  logic             full;
  logic             ram_re;
  logic [PTR_W-1:0] ram_raddr;
  logic [SW-1:0]    ram_rdata;
  logic             div_done;
  logic [SUM_W-1:0] div_quo;
  logic [F_W-1:0]   writable;

  // channel count register and derived capacity
  always_comb begin
    if (cfg_wdata_i == '0) begin
      ch_d = CH_W'(1);
    end else if ({1'b0, cfg_wdata_i} > (oarb_pkg::CFG_W+1)'(MAX_CHANNELS)) begin
      ch_d = CH_W'(MAX_CHANNELS);
    end else begin
      ch_d = CH_W'(cfg_wdata_i);
    end
    cap_d = CAP_W'(FRAMES) * CAP_W'(ch_d);
  end

  assign rp_inc  = {1'b0, rp_q} + 1'b1;
  assign wp_inc  = {1'b0, wp_q} + 1'b1;
  assign rp_next = (rp_inc >= (PTR_W+1)'(cap_q)) ? '0 : rp_inc[PTR_W-1:0];
  assign wp_next = (wp_inc >= (PTR_W+1)'(cap_q)) ? '0 : wp_inc[PTR_W-1:0];
  assign full    = (f_q == F_W'(FRAMES));

  assign pos_sum = (CAP_W+1)'(rp_q) + (CAP_W+1)'(item_q.channel_sel) + (CAP_W+1)'(prod_q);
  assign pos     = (pos_sum >= (CAP_W+1)'(cap_q)) ? pos_sum - (CAP_W+1)'(cap_q) : pos_sum;

  assign ram_re    = cmd_i.read_one | cmd_i.mono_start | cmd_i.peek_read |
                     (cmd_i.mono_step & (left_q != '0));
  assign ram_raddr = cmd_i.peek_read ? pos[PTR_W-1:0] : rp_q;

  always_comb begin
    rp_d   = rp_q;
    wp_d   = wp_q;
    f_d    = f_q;
    r_d    = r_q;
    left_d = left_q;
    pend_d = pend_q;
    if (cmd_i.ptr_clear) begin
      rp_d = '0;
      wp_d = '0;
      f_d  = '0;
      r_d  = '0;
    end
    if (cmd_i.ram_write) begin
      wp_d = wp_next;
      if (full) begin
        rp_d = rp_next;
      end else if (r_q + 1'b1 == ch_q) begin
        f_d = f_q + 1'b1;
        r_d = '0;
      end else begin
        r_d = r_q + 1'b1;
      end
    end
    if (cmd_i.read_one) begin
      rp_d = rp_next;
      if (r_q == '0) begin
        f_d = f_q - 1'b1;
        r_d = ch_q - 1'b1;
      end else begin
        r_d = r_q - 1'b1;
      end
    end
    if (cmd_i.mono_start) begin
      rp_d   = rp_next;
      f_d    = f_q - 1'b1;
      left_d = ch_q - 1'b1;
      pend_d = 1'b1;
    end
    if (cmd_i.mono_step) begin
      if (left_q != '0) begin
        rp_d   = rp_next;
        left_d = left_q - 1'b1;
        pend_d = 1'b1;
      end else begin
        pend_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ch_q   <= CH_W'(CH_RST);
      cap_q  <= CAP_W'(FRAMES * CH_RST);
      rp_q   <= '0;
      wp_q   <= '0;
      f_q    <= '0;
      r_q    <= '0;
      left_q <= '0;
      pend_q <= 1'b0;
    end else if (cfg_we_i) begin
      ch_q  <= ch_d;
      cap_q <= cap_d;
      rp_q  <= '0;
      wp_q  <= '0;
      f_q   <= '0;
      r_q   <= '0;
    end else begin
      rp_q   <= rp_d;
      wp_q   <= wp_d;
      f_q    <= f_d;
      r_q    <= r_d;
      left_q <= left_d;
      pend_q <= pend_d;
    end
  end

  assign writable = (r_q == '0) ? (F_W'(FRAMES) - f_q) : (F_W'(FRAMES) - f_q - 1'b1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.item_load) begin
      item_q <= item_i;
      prod_q <= PROD_W'(item_i.frame_offset) * PROD_W'(ch_q);
    end
    if (cmd_i.mono_start) begin
      acc_q <= '0;
    end else if (cmd_i.mono_step && pend_q) begin
      acc_q <= acc_q + {{(SUM_W-SW){ram_rdata[SW-1]}}, ram_rdata};
    end
    if (cmd_i.status_load) begin
      status_q <= cmd_i.status;
      sample_q <= '0;
    end else if (cmd_i.sample_from_ram) begin
      sample_q <= ram_rdata;
    end else if (cmd_i.sample_from_div) begin
      sample_q <= div_quo[SW-1:0];
    end
    if (cmd_i.out_load) begin
      out_q.sample_out       <= sample_q;
      out_q.status           <= status_q;
      out_q.frames_available <= oarb_pkg::FRM_W'(f_q);
      out_q.frames_writable  <= oarb_pkg::FRM_W'(writable);
    end
  end

  oarb_ram #(
    .WIDTH (SW),
    .DEPTH (STORE)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.ram_write),
    .waddr_i (wp_q),
    .wdata_i (item_q.sample_in),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  oarb_div #(
    .NUM_W (SUM_W),
    .DEN_W (CH_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (acc_q),
    .den_i   (ch_q),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  always_comb begin
    stat_o.cmd       = oarb_pkg::cmd_e'(item_q.cmd);
    stat_o.empty     = (f_q == '0) && (r_q == '0);
    stat_o.no_frame  = (f_q == '0);
    stat_o.full      = full;
    stat_o.sel_bad   = ((oarb_pkg::SEL_W+CH_W)'(item_q.channel_sel) >=
                        (oarb_pkg::SEL_W+CH_W)'(ch_q));
    stat_o.off_bad   = ((oarb_pkg::OFF_W+F_W)'(item_q.frame_offset) >=
                        (oarb_pkg::OFF_W+F_W)'(f_q));
    stat_o.mono_done = (left_q == '0) && !pend_q;
    stat_o.div_done  = div_done;
  end

  assign res_o = out_q;
  assign ch_o  = ch_q;

endmodule

// File: hw/rtl/overwriting_audio_ring_buffer_core.sv
// top level of the overwriting interleaved audio ring buffer
// one command at a time; write, clear and errors pass the dispatch and response states,
// sample read and peek add a wait state for the registered ram read, and a mono read
// (20-bit sum by default) adds the channel walk and the bit-serial divider.
// next command is accepted in the cycle after the result enters the output register.
// reset is asynchronous, active low: channel count 2, empty, no ram clearing pass needed.
module overwriting_audio_ring_buffer_core #(
  parameter int FRAMES       = 512,
  parameter int MAX_CHANNELS = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  oarb_cmd_if.sink                      cmd_i,
  oarb_res_if.source                    res_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [oarb_pkg::APB_AW-1:0]   paddr,
  input  logic [oarb_pkg::APB_DW-1:0]   pwdata,
  output logic [oarb_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);

  localparam int CH_W = $clog2(MAX_CHANNELS + 1);

  oarb_pkg::ctrl_cmd_t ctrl_cmd;
  oarb_pkg::dp_stat_t  dp_stat;
  logic                cfg_sel;
  logic                cfg_we;
  logic [CH_W-1:0]     ch;

  assign cfg_sel = (paddr[oarb_pkg::APB_AW-1:2] == oarb_pkg::REG_CH_COUNT);
  assign cfg_we  = psel & penable & pwrite & cfg_sel;
  assign pready  = 1'b1;
  assign prdata  = cfg_sel ? oarb_pkg::APB_DW'(ch) : '0;

  oarb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_i.valid),
    .cmd_ready_o (cmd_i.ready),
    .res_valid_o (res_o.valid),
    .res_ready_i (res_o.ready),
    .stat_i      (dp_stat),
    .cmd_o       (ctrl_cmd)
  );

  oarb_dp #(
    .FRAMES       (FRAMES),
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (cmd_i.data),
    .cmd_i       (ctrl_cmd),
    .stat_o      (dp_stat),
    .res_o       (res_o.data),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (pwdata[oarb_pkg::CFG_W-1:0]),
    .ch_o        (ch)
  );

endmodule

// File: hw/rtl/oarb_chk.sv
// port-level checker of the ring buffer and its bind
module oarb_chk (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           cmd_valid_i,
  input logic           cmd_ready_i,
  input logic           res_valid_i,
  input logic           res_ready_i,
  input oarb_pkg::res_t res_i
);

  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i)
    else $error("result beat dropped while stalled");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid_i && cmd_ready_i |=> !cmd_ready_i)
    else $error("command taken while previous one still in flight");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && (res_i.status != oarb_pkg::ST_OK) |-> (res_i.sample_out == '0))
    else $error("nonzero sample with non-ok status");

  a_overwrite_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && (res_i.status == oarb_pkg::ST_OVERWRITE) |-> (res_i.frames_writable == '0))
    else $error("overwrite reported with free frames");

endmodule

bind overwriting_audio_ring_buffer_core oarb_chk u_oarb_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .cmd_valid_i (cmd_i.valid),
  .cmd_ready_i (cmd_i.ready),
  .res_valid_i (res_o.valid),
  .res_ready_i (res_o.ready),
  .res_i       (res_o.data)
);
